// ===== rtl/core/mlfq_task_scheduler_core_assert.svh =====
// ---------------------------------------------------------------------------
// mlfq task scheduler assertion macros
// concurrent assertion wrappers for clocked implication checks on clk / rst_n
// ---------------------------------------------------------------------------
`ifndef MLFQ_TASK_SCHEDULER_CORE_ASSERT_SVH
`define MLFQ_TASK_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// mts_pkg
// shared constants, codes and control structs of the mlfq task scheduler
// ---------------------------------------------------------------------------
package mts_pkg;

  localparam int DEF_LEVEL1_DEPTH = 16;
  localparam int DEF_LEVEL2_DEPTH = 16;
  localparam int DEF_LEVEL3_DEPTH = 16;
  localparam int DEF_ID_WIDTH     = 16;

  localparam int FIELD_ID_W = 16;
  localparam int NEED_W     = 16;
  localparam int RUN_W      = 16;
  localparam int LEVEL_W    = 2;
  localparam int QUANT_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_CREATE = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_IDLE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_1    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_2    = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_3    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_QUANTUM = 2'd1;

  localparam logic [QUANT_W-1:0] RST_LEVEL1_QUANTUM = 16'd50;
  localparam logic [QUANT_W-1:0] RST_LEVEL2_QUANTUM = 16'd200;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic dispatch;
  } sts_t;

  typedef struct packed {
    logic                  admitted;
    logic                  running_valid;
    logic [FIELD_ID_W-1:0] running_task;
    logic [LEVEL_W-1:0]    running_level;
    logic [RUN_W-1:0]      running_ticks;
    logic                  finished_valid;
    logic [FIELD_ID_W-1:0] finished_task;
    logic                  demoted;
    logic [COUNT_W-1:0]    count_level1;
    logic [COUNT_W-1:0]    count_level2;
    logic [COUNT_W-1:0]    count_level3;
  } res_t;

endpackage

// ===== rtl/core/mts_if.sv =====
// ---------------------------------------------------------------------------
// mts_if
// valid/ready channel interfaces: item input, result output, config write
// ---------------------------------------------------------------------------
interface mts_in_if
  import mts_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [FIELD_ID_W-1:0] task_id;
  logic [LEVEL_W-1:0]    task_level;
  logic [NEED_W-1:0]     task_need;

  modport source (output valid, action, task_id, task_level, task_need, input ready);
  modport sink (input valid, action, task_id, task_level, task_need, output ready);
endinterface

interface mts_out_if
  import mts_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  admitted;
  logic                  running_valid;
  logic [FIELD_ID_W-1:0] running_task;
  logic [LEVEL_W-1:0]    running_level;
  logic [RUN_W-1:0]      running_ticks;
  logic                  finished_valid;
  logic [FIELD_ID_W-1:0] finished_task;
  logic                  demoted;
  logic [COUNT_W-1:0]    count_level1;
  logic [COUNT_W-1:0]    count_level2;
  logic [COUNT_W-1:0]    count_level3;

  modport source (
    output valid, admitted, running_valid, running_task, running_level, running_ticks,
           finished_valid, finished_task, demoted, count_level1, count_level2,
           count_level3,
    input  ready
  );
  modport sink (
    input  valid, admitted, running_valid, running_task, running_level, running_ticks,
           finished_valid, finished_task, demoted, count_level1, count_level2,
           count_level3,
    output ready
  );
endinterface

interface mts_cfg_if
  import mts_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mts_ram.sv =====
// ---------------------------------------------------------------------------
// mts_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mts_fifo.sv =====
// ---------------------------------------------------------------------------
// mts_fifo
// one priority queue: head/tail/count pointers around a block ram, with a
// bypass for a pop of the entry pushed in the same cycle
// ---------------------------------------------------------------------------
module mts_fifo
  import mts_pkg::*;
#(
  parameter int DEPTH = DEF_LEVEL1_DEPTH,
  parameter int WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output logic               full,
  output logic               empty,
  output logic [COUNT_W-1:0] count_lo
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             byp_r;
  logic [WIDTH-1:0] hold_r;
  logic [WIDTH-1:0] ram_rdata;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign count_lo = COUNT_W'(cnt_r);
  assign rdata    = byp_r ? hold_r : ram_rdata;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
    end
    if (pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        byp_r <= push && empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push && empty) begin
      hold_r <= wdata;
    end
  end

  mts_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (wdata),
    .re    (pop),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/mts_dp.sv =====
// ---------------------------------------------------------------------------
// mts_dp
// scheduler datapath: item and config registers, running task record,
// the three level queues and the result register
// ---------------------------------------------------------------------------
module mts_dp
  import mts_pkg::*;
#(
  parameter int LEVEL1_DEPTH = DEF_LEVEL1_DEPTH,
  parameter int LEVEL2_DEPTH = DEF_LEVEL2_DEPTH,
  parameter int LEVEL3_DEPTH = DEF_LEVEL3_DEPTH,
  parameter int ID_WIDTH     = DEF_ID_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  in_action,
  input  logic [FIELD_ID_W-1:0] in_task_id,
  input  logic [LEVEL_W-1:0]    in_task_level,
  input  logic [NEED_W-1:0]     in_task_need,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output res_t                  res
);

  localparam int REC_W = ID_WIDTH + NEED_W + RUN_W;

  logic                  item_action_r;
  logic [ID_WIDTH-1:0]   item_id_r;
  logic [LEVEL_W-1:0]    item_level_r;
  logic [NEED_W-1:0]     item_need_r;
  logic [QUANT_W-1:0]    q1_r, q2_r;
  logic [LEVEL_W-1:0]    run_lvl_r;
  logic [ID_WIDTH-1:0]   rec_id_r;
  logic [NEED_W-1:0]     rec_need_r;
  logic [RUN_W-1:0]      rec_run_r;
  logic                  adm_r, fin_r, dem_r;
  logic [FIELD_ID_W-1:0] fin_id_r;
  res_t                  res_r;

  logic [2:0]            push, pop, push_g, pop_g, full, empty, nonempty, cr_push, dem_push;
  logic [COUNT_W-1:0]    cnt_lo [3];
  logic [REC_W-1:0]      rd [3];
  logic [REC_W-1:0]      rd_sel, wdata;

  logic                  is_tick, running, fin_c, over1, over2, dem_c, adm_c, idle_after;
  logic [RUN_W-1:0]      run_inc;
  logic [LEVEL_W-1:0]    disp_lvl, exec_lvl, lvl_o;
  logic [ID_WIDTH-1:0]   id_o;
  logic [RUN_W-1:0]      run_o;
  res_t                  res_c;

  assign is_tick = item_action_r == ACT_TICK;
  assign running = run_lvl_r != LVL_IDLE;
  assign run_inc = (rec_run_r == RUN_MAX) ? rec_run_r : rec_run_r + RUN_W'(1);

  assign fin_c = is_tick && running && (run_inc >= rec_need_r);
  assign over1 = is_tick && running && !fin_c && run_lvl_r == LVL_1 && run_inc >= q1_r;
  assign over2 = is_tick && running && !fin_c && run_lvl_r == LVL_2 && run_inc >= q2_r;

  // level-1 overrun falls through to level 3 when level 2 is full
  assign dem_push[0] = 1'b0;
  assign dem_push[1] = over1 && !full[1];
  assign dem_push[2] = (over1 && full[1] && !full[2]) || (over2 && !full[2]);
  assign dem_c       = |dem_push;

  assign cr_push[0] = !is_tick && item_level_r == LVL_1 && !full[0];
  assign cr_push[1] = !is_tick && item_level_r == LVL_2 && !full[1];
  assign cr_push[2] = !is_tick && item_level_r == LVL_3 && !full[2];
  assign adm_c      = |cr_push;

  assign push  = cr_push | dem_push;
  assign wdata = is_tick ? {rec_id_r, rec_need_r, run_inc}
                         : {item_id_r, item_need_r, {RUN_W{1'b0}}};

  assign idle_after = is_tick && (!running || fin_c || dem_c);
  assign nonempty   = ~empty | push;
  assign pop[0]     = idle_after && nonempty[0];
  assign pop[1]     = idle_after && !nonempty[0] && nonempty[1];
  assign pop[2]     = idle_after && !nonempty[0] && !nonempty[1] && nonempty[2];

  assign push_g       = push & {3{cmd.exec}};
  assign pop_g        = pop & {3{cmd.exec}};
  assign sts.dispatch = |pop;

  assign disp_lvl = pop[0] ? LVL_1 : (pop[1] ? LVL_2 : (pop[2] ? LVL_3 : LVL_IDLE));
  assign exec_lvl = idle_after ? LVL_IDLE : run_lvl_r;

  always_comb begin
    case (run_lvl_r)
      LVL_1:   rd_sel = rd[0];
      LVL_2:   rd_sel = rd[1];
      LVL_3:   rd_sel = rd[2];
      default: rd_sel = rd[0];
    endcase
  end

  // result from the exec cycle, or from the dispatch load cycle
  always_comb begin
    if (cmd.load) begin
      lvl_o = run_lvl_r;
      id_o  = rd_sel[REC_W-1 -: ID_WIDTH];
      run_o = rd_sel[RUN_W-1:0];
    end else begin
      lvl_o = exec_lvl;
      id_o  = rec_id_r;
      run_o = (is_tick && running) ? run_inc : rec_run_r;
    end
    res_c.admitted       = cmd.load ? adm_r : adm_c;
    res_c.finished_valid = cmd.load ? fin_r : fin_c;
    res_c.demoted        = cmd.load ? dem_r : dem_c;
    res_c.finished_task  = cmd.load ? fin_id_r
                                    : (fin_c ? FIELD_ID_W'(rec_id_r) : '0);
    res_c.running_valid  = lvl_o != LVL_IDLE;
    res_c.running_level  = lvl_o;
    res_c.running_task   = (lvl_o != LVL_IDLE) ? FIELD_ID_W'(id_o) : '0;
    res_c.running_ticks  = (lvl_o != LVL_IDLE) ? run_o : '0;
    res_c.count_level1   = cnt_lo[0] + COUNT_W'(push_g[0]) - COUNT_W'(pop_g[0]);
    res_c.count_level2   = cnt_lo[1] + COUNT_W'(push_g[1]) - COUNT_W'(pop_g[1]);
    res_c.count_level3   = cnt_lo[2] + COUNT_W'(push_g[2]) - COUNT_W'(pop_g[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_lvl_r <= LVL_IDLE;
      q1_r      <= RST_LEVEL1_QUANTUM;
      q2_r      <= RST_LEVEL2_QUANTUM;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEVEL1_QUANTUM: q1_r <= QUANT_W'(cfg_data);
          REG_LEVEL2_QUANTUM: q2_r <= QUANT_W'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.exec && idle_after) begin
        run_lvl_r <= disp_lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_action_r <= in_action;
      item_id_r     <= ID_WIDTH'(in_task_id);
      item_level_r  <= in_task_level;
      item_need_r   <= in_task_need;
    end
    if (cmd.exec) begin
      adm_r    <= adm_c;
      fin_r    <= fin_c;
      dem_r    <= dem_c;
      fin_id_r <= fin_c ? FIELD_ID_W'(rec_id_r) : '0;
      if (is_tick && running && !idle_after) begin
        rec_run_r <= run_inc;
      end
    end
    if (cmd.load) begin
      rec_id_r   <= rd_sel[REC_W-1 -: ID_WIDTH];
      rec_need_r <= rd_sel[RUN_W +: NEED_W];
      rec_run_r  <= rd_sel[RUN_W-1:0];
    end
    if (cmd.out_load) begin
      res_r <= res_c;
    end
  end

  assign res = res_r;

  mts_fifo #(.DEPTH(LEVEL1_DEPTH), .WIDTH(REC_W)) u_q1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_g[0]),
    .wdata    (wdata),
    .pop      (pop_g[0]),
    .rdata    (rd[0]),
    .full     (full[0]),
    .empty    (empty[0]),
    .count_lo (cnt_lo[0])
  );

  mts_fifo #(.DEPTH(LEVEL2_DEPTH), .WIDTH(REC_W)) u_q2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_g[1]),
    .wdata    (wdata),
    .pop      (pop_g[1]),
    .rdata    (rd[1]),
    .full     (full[1]),
    .empty    (empty[1]),
    .count_lo (cnt_lo[1])
  );

  mts_fifo #(.DEPTH(LEVEL3_DEPTH), .WIDTH(REC_W)) u_q3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_g[2]),
    .wdata    (wdata),
    .pop      (pop_g[2]),
    .rdata    (rd[2]),
    .full     (full[2]),
    .empty    (empty[2]),
    .count_lo (cnt_lo[2])
  );

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// ---------------------------------------------------------------------------
// mts_ctrl
// scheduler controller: item handshake, exec / dispatch-load sequencing and
// result register valid
// ---------------------------------------------------------------------------
module mts_ctrl
  import mts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.dispatch) begin
          cmd.exec  = 1'b1;
          state_nxt = S_LOAD;
        end else if (out_free) begin
          cmd.exec     = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load     = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/mlfq_task_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// mlfq_task_scheduler_core
// three-level feedback task scheduler with queues in block ram
// ---------------------------------------------------------------------------
// One item is handled at a time. A create, or a tick that starts no queued
// task, loads its result register from its exec state; a tick that dispatches
// a queued task goes on to a load state for the registered read of that
// level's queue ram. The next item is accepted in the cycle after the result
// register is loaded, while that beat may still wait for out ready; a full
// result register holds the following item in its exec cycle, or, for a tick
// that dispatches, in its load cycle after the queue pop. Config writes are
// always ready and take effect once registered, also on an item in flight.
module mlfq_task_scheduler_core
  import mts_pkg::*;
#(
  parameter int LEVEL1_DEPTH = DEF_LEVEL1_DEPTH,
  parameter int LEVEL2_DEPTH = DEF_LEVEL2_DEPTH,
  parameter int LEVEL3_DEPTH = DEF_LEVEL3_DEPTH,
  parameter int ID_WIDTH     = DEF_ID_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  mts_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  assign cfg_ch.ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mts_dp #(
    .LEVEL1_DEPTH (LEVEL1_DEPTH),
    .LEVEL2_DEPTH (LEVEL2_DEPTH),
    .LEVEL3_DEPTH (LEVEL3_DEPTH),
    .ID_WIDTH     (ID_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_task_id    (in_ch.task_id),
    .in_task_level (in_ch.task_level),
    .in_task_need  (in_ch.task_need),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .res           (res)
  );

  assign out_ch.admitted       = res.admitted;
  assign out_ch.running_valid  = res.running_valid;
  assign out_ch.running_task   = res.running_task;
  assign out_ch.running_level  = res.running_level;
  assign out_ch.running_ticks  = res.running_ticks;
  assign out_ch.finished_valid = res.finished_valid;
  assign out_ch.finished_task  = res.finished_task;
  assign out_ch.demoted        = res.demoted;
  assign out_ch.count_level1   = res.count_level1;
  assign out_ch.count_level2   = res.count_level2;
  assign out_ch.count_level3   = res.count_level3;

endmodule

// ===== rtl/core/mts_checker.sv =====
// ---------------------------------------------------------------------------
// mts_checker
// port-level checks of the mlfq task scheduler, bound to the top level
// ---------------------------------------------------------------------------
`include "mlfq_task_scheduler_core_assert.svh"

module mts_checker
  import mts_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_admitted,
  input logic               out_running_valid,
  input logic [LEVEL_W-1:0] out_running_level,
  input logic               out_finished_valid,
  input logic               out_demoted
);

  `MTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `MTS_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken in flight")
  `MTS_ASSERT_IMP(a_fin_dem, out_valid, !(out_finished_valid && out_demoted), "finish and demote")
  `MTS_ASSERT_IMP(a_admit_only, out_valid && out_admitted, !out_finished_valid && !out_demoted, "admit on tick")
  `MTS_ASSERT_IMP(a_run_lvl, out_valid, out_running_valid == (out_running_level != LVL_IDLE), "running level mismatch")

endmodule

bind mlfq_task_scheduler_core mts_checker u_mts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_admitted       (out_ch.admitted),
  .out_running_valid  (out_ch.running_valid),
  .out_running_level  (out_ch.running_level),
  .out_finished_valid (out_ch.finished_valid),
  .out_demoted        (out_ch.demoted)
);
